@@ hw/rtl/crcfc_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the frame checker.
package crcfc_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEF = 1024;
  localparam int unsigned LEN_W             = 10;
  localparam int unsigned LEN_FIELD_MAX     = 1023;

  localparam logic [7:0]       CR_BYTE   = 8'd13;
  localparam logic [7:0]       PAD_BYTE  = 8'd0;
  localparam logic [15:0]      CRC_POLY  = 16'h1021;
  localparam logic [15:0]      CRC_MSB   = 16'h8000;
  localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(3);

  typedef enum logic [1:0] {
    STATUS_GOOD  = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
    logic [15:0]      calc_crc;
    logic [15:0]      received_crc;
  } result_t;

  // MSB-first CRC-16 update over one byte, eight shift steps unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/crc_frame_checker.sv @@
// Top level of the carriage-return framed CRC-16 checker.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one received
//   byte per transfer. A zero byte is padding and is dropped. A carriage
//   return ends the frame and produces exactly one result; any other byte
//   enters a two-byte delay line, and the byte leaving it updates the
//   running CRC-16 (poly 0x1021, init 0, MSB first).
//   Result channel (out_valid / out_stall / out_*) carries status, length,
//   computed CRC and the received CRC taken big-endian from the held bytes.
//   Frames with fewer than 3 bytes report too short with zero CRC fields.
// Timing:
//   One byte per cycle while in_stall is low. The CRC update is an unrolled
//   8-step shift network in the next-state logic of the CRC register; a
//   result is registered in the output register, or in the skid stage if held.
//   Stall: a result held by out_stall leaves the input open; a second result
//   parks in a skid stage, and only then does in_stall rise until the
//   receiver takes a transfer.
// Reset: rst_n (synchronous, active low) empties the output path and clears
//   the CRC, the delay line and the byte count.
module crc_frame_checker #(
  parameter int unsigned MAX_FRAME_LEN = crcfc_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_frame_status,
  output logic [crcfc_pkg::LEN_W-1:0]  out_frame_length,
  output logic [15:0]                  out_calc_crc,
  output logic [15:0]                  out_received_crc
);
  import crcfc_pkg::*;

  // Count saturates at the lesser of the buffer size less one and the field max.
  localparam logic [LEN_W-1:0] COUNT_LIMIT = (MAX_FRAME_LEN - 1 > LEN_FIELD_MAX)
                                             ? LEN_W'(LEN_FIELD_MAX)
                                             : LEN_W'(MAX_FRAME_LEN - 1);

  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;

  logic    accept;
  logic    is_cr;
  logic    is_pad;
  logic    push;
  logic    buf_full;
  result_t res;
  result_t out_res;

  assign accept = in_valid && !in_stall;
  assign is_cr  = (in_rx_byte == CR_BYTE);
  assign is_pad = (in_rx_byte == PAD_BYTE);
  assign push   = accept && is_cr;

  // Build the frame result from the state as it stands before this byte.
  always_comb begin
    res.length = count_r;
    if (count_r < MIN_FRAME) begin
      res.status       = STATUS_SHORT;
      res.calc_crc     = 16'h0000;
      res.received_crc = 16'h0000;
    end else begin
      res.calc_crc     = crc_r;
      res.received_crc = {held0_r, held1_r};
      res.status       = (crc_r == {held0_r, held1_r}) ? STATUS_GOOD : STATUS_BAD;
    end
  end

  // Advance the delay line and CRC on data bytes, clear on carriage return,
  // hold on padding or no transfer.
  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    count_nxt = count_r;
    if (accept && !is_pad) begin
      if (is_cr) begin
        crc_nxt   = 16'h0000;
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
        count_nxt = '0;
      end else begin
        if (count_r >= LEN_W'(2)) begin
          crc_nxt = crc_byte(crc_r, held0_r);
        end
        held0_nxt = held1_r;
        held1_nxt = in_rx_byte;
        if (count_r < COUNT_LIMIT) begin
          count_nxt = count_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= 16'h0000;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      count_r <= '0;
    end else begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      count_r <= count_nxt;
    end
  end

  crcfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Stall only while the skid stage holds a result.
  assign in_stall = buf_full;

  assign out_frame_status = out_res.status;
  assign out_frame_length = out_res.length;
  assign out_calc_crc     = out_res.calc_crc;
  assign out_received_crc = out_res.received_crc;

  // A parked result in the skid implies the output slot is occupied.
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // Every accepted carriage return leaves out_valid high on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) push |=> out_valid)
    else $error("carriage return produced no result");

  // Padding leaves the frame state untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_pad |=> $stable(crc_r) && $stable(count_r) && $stable(held1_r))
    else $error("padding byte changed frame state");

  // Short frames report zero CRC fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    push && (count_r < MIN_FRAME) |->
      (res.calc_crc == 16'h0000) && (res.received_crc == 16'h0000))
    else $error("short frame carried a nonzero CRC");

endmodule

@@ hw/rtl/crcfc_out_buf.sv @@
// Output register with a one-entry skid stage for frame results.
module crcfc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crcfc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output crcfc_pkg::result_t out_data
);
  import crcfc_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      // output slot frees up: drain the skid first, else take the new result
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
